@@ hdl/pida_pkg.sv @@
// Shared types and constants for the positional insert/delete array.
// Used by pida_ctrl, pida_dpath and positional_insert_delete_array.
// No dependencies.
package pida_pkg;

  // Default capacity of the element store.
  localparam int DEPTH_DEF = 64;

  // Fixed field widths of the request and result items.
  localparam int OP_W     = 2;
  localparam int WORD_W   = 32;
  localparam int POS_W    = 7;
  localparam int IDX_W    = 6;
  localparam int CNT_W    = 7;
  localparam int STAT_W   = 2;
  localparam int IN_TD_W  = 40;
  localparam int OUT_TD_W = 48;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_LIST   = 2'd2;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd2;
  localparam logic [STAT_W-1:0] ST_BADPOS = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;  // capture the accepted request
    logic fetch;  // register the element at the current read address
    logic emit;   // load the result register and apply the state change
  } pida_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;   // result register can take a new result this cycle
    logic list_more;  // a list request has further elements after this one
  } pida_sts_t;

endpackage

@@ hdl/positional_insert_delete_array.sv @@
// Top level of the positional insert/delete array: stream ports, the
// controller and the datapath. Depends on pida_pkg, pida_ctrl, pida_dpath.
//
//   Port group   Direction  Carries
//   in_*         slave      request: opcode in tuser, value and position in tdata
//   out_*        master     result: status in tuser, data/index/count in tdata, tlast
//
// An insert, delete or failed request passes the FETCH and EXEC states
// before it reaches the result register; in_tready rises again in IDLE, so
// no new request is taken until the last is through. A list gives one
// result per FETCH and EXEC pass, as the cell row has a registered read port.
// rst_n is synchronous and clears the count and the handshake state; the cells
// are not cleared. A stalled out_tready holds the result and the controller.
module positional_insert_delete_array
  import pida_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [IN_TD_W-1:0]  in_tdata,   // [31:0] value, [38:32] position
  input  logic [OP_W-1:0]     in_tuser,   // [1:0] opcode
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OUT_TD_W-1:0] out_tdata,  // [31:0] data, [37:32] index, [44:38] count
  output logic [STAT_W-1:0]   out_tuser,  // [1:0] status
  output logic                out_tlast
);

  pida_cmd_t cmd;
  pida_sts_t sts;

  logic signed [WORD_W-1:0] res_data;
  logic [IDX_W-1:0]         res_index;
  logic [CNT_W-1:0]         res_count;

  pida_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pida_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_op      (in_tuser),
    .in_value   (in_tdata[WORD_W-1:0]),
    .in_pos     (in_tdata[WORD_W+POS_W-1:WORD_W]),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_status (out_tuser),
    .out_data   (res_data),
    .out_index  (res_index),
    .out_count  (res_count),
    .out_last   (out_tlast)
  );

  // Pack the result fields, padded with zeros to whole bytes.
  assign out_tdata = {{(OUT_TD_W - WORD_W - IDX_W - CNT_W){1'b0}},
                      res_count, res_index, res_data};

endmodule

@@ hdl/pida_ctrl.sv @@
// Controller state machine for the positional insert/delete array.
// Depends on pida_pkg for the command and status structs.
module pida_ctrl
  import pida_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  pida_sts_t sts,
  output pida_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_FETCH = 3'b010,
    S_EXEC  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.latch = 1'b1;
          state_nxt = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = sts.list_more ? S_FETCH : S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ hdl/pida_dpath.sv @@
// Datapath for the positional insert/delete array: the shifting cell row,
// the element count, the registered read port and the result register.
// Depends on pida_pkg for widths, codes and the command and status structs.
module pida_dpath
  import pida_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  pida_cmd_t                cmd,
  output pida_sts_t                sts,
  input  logic [OP_W-1:0]          in_op,
  input  logic signed [WORD_W-1:0] in_value,
  input  logic [POS_W-1:0]         in_pos,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [STAT_W-1:0]        out_status,
  output logic signed [WORD_W-1:0] out_data,
  output logic [IDX_W-1:0]         out_index,
  output logic [CNT_W-1:0]         out_count,
  output logic                     out_last
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

  // Latched request and list position.
  logic [OP_W-1:0]          op_r;
  logic signed [WORD_W-1:0] val_r;
  logic [POS_W-1:0]         pos_r;
  logic [CNT_W-1:0]         lst_r, lst_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;

  // Cell row and registered read data.
  logic signed [WORD_W-1:0] cells_r [DEPTH];
  logic signed [WORD_W-1:0] rd_data_r;
  logic [AW-1:0]            rd_addr;

  // Result register.
  logic                     out_valid_r;
  logic [STAT_W-1:0]        out_status_r, out_status_nxt;
  logic signed [WORD_W-1:0] out_data_r, out_data_nxt;
  logic [IDX_W-1:0]         out_index_r, out_index_nxt;
  logic [CNT_W-1:0]         out_count_r;
  logic                     out_last_r, out_last_nxt;

  logic ins_ok, del_ok;

  // Request capture.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r  <= in_op;
      val_r <= in_value;
      pos_r <= in_pos;
    end
  end

  // Decode the outcome of the latched request against the current count.
  always_comb begin
    ins_ok         = 1'b0;
    del_ok         = 1'b0;
    out_status_nxt = ST_BADPOS;
    out_data_nxt   = '0;
    out_index_nxt  = '0;
    out_last_nxt   = 1'b1;
    count_nxt      = count_r;
    lst_nxt        = lst_r + CNT_W'(1);
    case (op_r)
      OP_INSERT: begin
        if (count_r == DEPTH_C) begin
          out_status_nxt = ST_FULL;
        end else if (pos_r <= count_r) begin
          ins_ok         = 1'b1;
          out_status_nxt = ST_OK;
          out_data_nxt   = val_r;
          out_index_nxt  = pos_r[IDX_W-1:0];
          count_nxt      = count_r + CNT_W'(1);
        end
      end
      OP_DELETE: begin
        if (count_r == '0) begin
          out_status_nxt = ST_EMPTY;
        end else if (pos_r < count_r) begin
          del_ok         = 1'b1;
          out_status_nxt = ST_OK;
          out_data_nxt   = rd_data_r;
          out_index_nxt  = pos_r[IDX_W-1:0];
          count_nxt      = count_r - CNT_W'(1);
        end
      end
      OP_LIST: begin
        if (count_r == '0) begin
          out_status_nxt = ST_EMPTY;
        end else begin
          out_status_nxt = ST_OK;
          out_data_nxt   = rd_data_r;
          out_index_nxt  = lst_r[IDX_W-1:0];
          out_last_nxt   = (lst_nxt == count_r);
        end
      end
      default: begin
        out_status_nxt = ST_BADPOS;
      end
    endcase
  end

  // Read address: the delete position, or the next element of a list.
  assign rd_addr = (op_r == OP_LIST) ? lst_r[AW-1:0] : pos_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      rd_data_r <= cells_r[rd_addr];
    end
  end

  // From pos_r up, cells take the cell below on insert (pos_r takes the value), above on delete.
  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (cmd.emit && ins_ok) begin
        if (POS_W'(i) == pos_r) begin
          cells_r[i] <= val_r;
        end else if (POS_W'(i) > pos_r) begin
          cells_r[i] <= cells_r[(i > 0) ? i - 1 : 0];
        end
      end else if (cmd.emit && del_ok && (POS_W'(i) >= pos_r) && (i < DEPTH - 1)) begin
        cells_r[i] <= cells_r[(i < DEPTH - 1) ? i + 1 : i];
      end
    end
  end

  // Element count and list position.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      lst_r   <= '0;
    end else begin
      if (cmd.emit) begin
        count_r <= count_nxt;
      end
      if (cmd.latch) begin
        lst_r <= '0;
      end else if (cmd.emit) begin
        lst_r <= lst_nxt;
      end
    end
  end

  // Result register: holds a result until the consumer takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status_r <= out_status_nxt;
      out_data_r   <= out_data_nxt;
      out_index_r  <= out_index_nxt;
      out_count_r  <= count_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

  assign sts.out_free  = !out_valid_r || out_ready;
  assign sts.list_more = !out_last_nxt;

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_data   = out_data_r;
  assign out_index  = out_index_r;
  assign out_count  = out_count_r;
  assign out_last   = out_last_r;

endmodule
